FILE: sv/rtp_pkg.sv
// Shared types, constants and the digit decode function of the radix integer text parser.
package rtp_pkg;

	localparam int POSITION_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_MODE = 2'd1;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] NO_DIGIT = 6'd63;

	localparam logic [7:0] CHAR_FIRST_BLANK = 8'd1;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NO_DIGIT = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [63:0] LIMIT_WIDE = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIMIT_NARROW = 64'h0000_0000_FFFF_FFFF;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGN,
		PH_DIGS
	} phase_t;

	typedef enum logic [2:0] {
		CLS_BLANK,
		CLS_PLUS,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_OTHER
	} char_class_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_SIGN,
		ACT_FIRST_DIGIT,
		ACT_NO_DIGIT,
		ACT_ACCUM,
		ACT_OVERFLOW,
		ACT_FINISH
	} action_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_char;
	} char_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] result_value;
		logic [15:0]        end_position;
	} result_item_t;

	typedef struct packed {
		logic        first;
		char_class_t cls;
		logic [5:0]  digit;
	} class_entry_t;

	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [5:0] d;
		d = NO_DIGIT;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 6'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			d = 6'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = 6'(c - 8'h61 + 8'd10);
		end
		return d;
	endfunction

endpackage

FILE: sv/rtp_front.sv
// Front end: accepts characters and classifies them into queue entries.
module rtp_front
	import rtp_pkg::*;
(
	input  logic         char_valid,
	output logic         char_stall,
	input  char_item_t   char_item,
	input  logic [5:0]   radix_eff,
	input  logic         queue_full,
	output logic         push,
	output class_entry_t push_entry
);

	logic [5:0] digit;
	logic       is_digit;

	assign digit = digit_value(char_item.char_code);
	assign is_digit = (digit < radix_eff);

	always_comb begin
		push_entry.first = char_item.first_char;
		push_entry.digit = digit;
		priority if (char_item.char_code >= CHAR_FIRST_BLANK
				&& char_item.char_code <= CHAR_SPACE) begin
			push_entry.cls = CLS_BLANK;
		end else if (char_item.char_code == CHAR_PLUS) begin
			push_entry.cls = CLS_PLUS;
		end else if (char_item.char_code == CHAR_MINUS) begin
			push_entry.cls = CLS_MINUS;
		end else if (is_digit) begin
			push_entry.cls = CLS_DIGIT;
		end else begin
			push_entry.cls = CLS_OTHER;
		end
	end

	assign char_stall = queue_full;
	assign push = char_valid && !queue_full;

endmodule

FILE: sv/rtp_queue.sv
// Short queue of classified characters between the front end and the back end.
module rtp_queue
	import rtp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  class_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output class_entry_t head
);

	class_entry_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: sv/rtp_back.sv
// Back end: parse state machine, radix accumulator and result register.
module rtp_back
	import rtp_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [5:0]   radix_eff,
	input  logic         wide_mode,
	input  logic         head_valid,
	input  class_entry_t head,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item
);

	phase_t                   phase_q;
	phase_t                   phase_eff;
	phase_t                   phase_next;
	action_t                  act;
	logic [63:0]              acc_q;
	logic                     neg_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_eff;
	logic [15:0]              pos_out;
	logic [63:0]              limit;
	logic [69:0]              prod;
	logic [69:0]              sum;
	logic                     ovf;
	logic [63:0]              signed_val;
	logic [63:0]              final_val;
	logic                     emit;
	logic [1:0]               status;
	logic [63:0]              value;
	logic                     result_valid_q;
	result_item_t             result_q;

	assign pop = head_valid && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result_item = result_q;

	assign phase_eff = head.first ? PH_LEAD : phase_q;
	assign pos_eff = head.first ? '0 : pos_q;
	assign limit = wide_mode ? LIMIT_WIDE : LIMIT_NARROW;

	assign prod = 70'(acc_q) * 70'(radix_eff);
	assign sum = prod + 70'(head.digit);
	assign ovf = (sum > 70'(limit));

	assign signed_val = neg_q ? (64'd0 - acc_q) : acc_q;
	assign final_val = wide_mode ? signed_val : {{32{signed_val[31]}}, signed_val[31:0]};

	generate
		if (POSITION_BITS > 16) begin : g_pos_sat
			assign pos_out = (|pos_eff[POSITION_BITS-1:16]) ? 16'hFFFF : pos_eff[15:0];
		end else begin : g_pos_ext
			assign pos_out = 16'(pos_eff);
		end
	endgenerate

	always_comb begin
		act = ACT_NONE;
		unique case (phase_eff)
			PH_IDLE: begin
				act = ACT_NONE;
			end
			PH_LEAD: begin
				priority case (head.cls)
					CLS_BLANK: act = ACT_NONE;
					CLS_PLUS, CLS_MINUS: act = ACT_SIGN;
					CLS_DIGIT: act = ACT_FIRST_DIGIT;
					default: act = ACT_NO_DIGIT;
				endcase
			end
			PH_SIGN: begin
				act = (head.cls == CLS_DIGIT) ? ACT_FIRST_DIGIT : ACT_NO_DIGIT;
			end
			PH_DIGS: begin
				priority if (head.cls != CLS_DIGIT) begin
					act = ACT_FINISH;
				end else if (ovf) begin
					act = ACT_OVERFLOW;
				end else begin
					act = ACT_ACCUM;
				end
			end
			default: act = ACT_NONE;
		endcase
	end

	always_comb begin
		unique case (act)
			ACT_NONE: phase_next = phase_eff;
			ACT_SIGN: phase_next = PH_SIGN;
			ACT_FIRST_DIGIT, ACT_ACCUM: phase_next = PH_DIGS;
			ACT_NO_DIGIT, ACT_OVERFLOW, ACT_FINISH: phase_next = PH_IDLE;
			default: phase_next = phase_eff;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		status = STATUS_OK;
		value = '0;
		unique case (act)
			ACT_NO_DIGIT: begin
				emit = 1'b1;
				status = STATUS_NO_DIGIT;
			end
			ACT_OVERFLOW: begin
				emit = 1'b1;
				status = STATUS_OVERFLOW;
			end
			ACT_FINISH: begin
				emit = 1'b1;
				if (acc_q >= limit) begin
					status = STATUS_OVERFLOW;
				end else begin
					value = final_val;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			neg_q <= 1'b0;
			pos_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_next;
				if (act == ACT_SIGN) begin
					neg_q <= (head.cls == CLS_MINUS);
				end else if (head.first) begin
					neg_q <= 1'b0;
				end
				if (act == ACT_FIRST_DIGIT) begin
					acc_q <= 64'(head.digit);
				end else if (act == ACT_ACCUM) begin
					acc_q <= sum[63:0];
				end else if (head.first) begin
					acc_q <= '0;
				end
				if (phase_eff != PH_IDLE) begin
					pos_q <= (&pos_eff) ? pos_eff : pos_eff + 1'b1;
				end
			end
			if (pop && emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_q.status <= status;
			result_q.result_value <= value;
			result_q.end_position <= pos_out;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.status != 2'd3))
		else $error("Result status holds an undefined code.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status != STATUS_OK) |-> (result_q.result_value == 64'sd0))
		else $error("Failed parse carries a nonzero value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |-> !pop)
		else $error("Queue popped while a stalled result is pending.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (phase_q == PH_IDLE))
		else $error("Parser did not return to idle after a result.");
`endif

endmodule

FILE: sv/radix_integer_text_parser_core.sv
// Radix integer text parser top level: configuration registers, front end, queue and back end.
// A result reaches the output register when the back end pops its ending character, which the
// queue wrote when it accepted that character; a stalled result can hold that pop back.
// Throughput: one character per cycle while the queue is not full and result_stall is low; the
// back end's 64-by-6-bit multiply-add and range compare are combinational and set that rate.
// Reset: arst_n clears the parse state, the queue and the output valid at once and loads
// radix 10 and 32-bit mode; no clearing pass is needed.
module radix_integer_text_parser_core
	import rtp_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  char_item_t                char_item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_item_t              result_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [5:0]   radix_q;
	logic         wide_mode_q;
	logic [5:0]   radix_eff;
	logic         queue_full;
	logic         push;
	class_entry_t push_entry;
	logic         pop;
	logic         head_valid;
	class_entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			wide_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RADIX) begin
				radix_q <= cfg_data;
			end else if (cfg_index == REG_WIDE_MODE) begin
				wide_mode_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	rtp_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.radix_eff  (radix_eff),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rtp_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_eff    (radix_eff),
		.wide_mode    (wide_mode_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
